>>> rtl/core/tjs_pkg.sv
// shared types, constants and helpers of the two-joint vertex skinning block
package tjs_pkg;

  localparam int JointsDef  = 32;
  localparam int Words      = 12;
  localparam int JIdxW      = 7;
  localparam int TransRow   = 9;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef logic signed [31:0] word_t;
  typedef word_t [Words-1:0] mat_t;
  typedef word_t [2:0] vec3_t;

  typedef struct packed {
    logic              kind;
    logic [4:0]        load_joint;
    logic [3:0]        load_element;
    logic signed [31:0] load_value;
    logic [20:0]       blend_weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
  } tjs_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_nrm_x;
    logic signed [31:0] out_nrm_y;
    logic signed [31:0] out_nrm_z;
    logic               joint_clamped;
  } tjs_out_t;

  // matrix rows of both joints plus the vertex, as read from the tables
  typedef struct packed {
    mat_t        mat_a;
    mat_t        mat_b;
    logic [15:0] frac;
    vec3_t       pos;
    vec3_t       nrm;
    logic        clamped;
  } tjs_fetch_t;

  // blended matrix with the vertex
  typedef struct packed {
    mat_t  mat;
    vec3_t pos;
    vec3_t nrm;
    logic  clamped;
  } tjs_blend_t;

  // floor of a Q32.32 product to Q32.16 with the integer part kept
  function automatic logic signed [47:0] floor_q16(input logic signed [63:0] p);
    floor_q16 = p[63:16];
  endfunction

endpackage

>>> rtl/core/tjs_if.sv
// valid/ready channels for vertex items and skinned results
interface tjs_in_if;
  logic              valid;
  logic              ready;
  tjs_pkg::tjs_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tjs_out_if;
  logic              valid;
  logic              ready;
  tjs_pkg::tjs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/tjs_ram.sv
// generic ram, one write port, two registered read ports
module tjs_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

>>> rtl/core/tjs_blend.sv
// matrix blend: two stages, (b - a) * f then a + floor
module tjs_blend (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  tjs_pkg::tjs_fetch_t fetch_i,
  output logic                valid_o,
  input  logic                ready_i,
  output tjs_pkg::tjs_blend_t blend_o
);
  import tjs_pkg::*;

  logic               v2_q, v3_q;
  logic               en2, en3;
  logic signed [49:0] prod_d [Words];
  logic signed [49:0] prod_q [Words];
  mat_t               a_q;
  vec3_t              pos2_q, nrm2_q;
  logic               clamp2_q;
  tjs_blend_t         blend_d, blend_q;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign ready_o = en2;

  // weighted difference per word
  always_comb begin
    for (int e = 0; e < Words; e++) begin
      prod_d[e] = (33'($signed(fetch_i.mat_b[e])) - 33'($signed(fetch_i.mat_a[e])))
                  * $signed({1'b0, fetch_i.frac});
    end
  end

  // blended word, always between its two sources
  always_comb begin
    blend_d.pos     = pos2_q;
    blend_d.nrm     = nrm2_q;
    blend_d.clamped = clamp2_q;
    for (int e = 0; e < Words; e++) begin
      blend_d.mat[e] = $signed(a_q[e]) + $signed(prod_q[e][47:16]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en2) v2_q <= valid_i;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod_q   <= prod_d;
      a_q      <= fetch_i.mat_a;
      pos2_q   <= fetch_i.pos;
      nrm2_q   <= fetch_i.nrm;
      clamp2_q <= fetch_i.clamped;
    end
    if (en3) begin
      blend_q <= blend_d;
    end
  end

  assign valid_o = v3_q;
  assign blend_o = blend_q;

endmodule

>>> rtl/core/tjs_xform.sv
// vertex transform: products, sums, saturating output register
module tjs_xform (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  tjs_pkg::tjs_blend_t blend_i,
  tjs_out_if.source           res_o
);
  import tjs_pkg::*;

  localparam logic signed [49:0] SatMax = 50'sd2147483647;
  localparam logic signed [49:0] SatMin = -50'sd2147483648;

  logic               v4_q, v5_q, v6_q;
  logic               en4, en5, en6;
  logic signed [63:0] pp_d [3][3];
  logic signed [63:0] pp_q [3][3];
  logic signed [63:0] np_d [3][3];
  logic signed [63:0] np_q [3][3];
  vec3_t              tr_q;
  logic               clamp4_q, clamp5_q;
  logic signed [49:0] ps_d [3];
  logic signed [49:0] ps_q [3];
  logic signed [49:0] ns_d [3];
  logic signed [49:0] ns_q [3];
  word_t              po [3];
  word_t              no [3];
  tjs_out_t           out_q;

  assign en6     = !v6_q || res_o.ready;
  assign en5     = !v5_q || en6;
  assign en4     = !v4_q || en5;
  assign ready_o = en4;

  // products: column c of the 3x3 part against each input component
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        pp_d[c][r] = $signed(blend_i.pos[r]) * $signed(blend_i.mat[r*3+c]);
        np_d[c][r] = $signed(blend_i.nrm[r]) * $signed(blend_i.mat[r*3+c]);
      end
    end
  end

  // floored products summed, translation on the position
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ps_d[c] = 50'(floor_q16(pp_q[c][0])) + 50'(floor_q16(pp_q[c][1]))
              + 50'(floor_q16(pp_q[c][2])) + 50'($signed(tr_q[c]));
      ns_d[c] = 50'(floor_q16(np_q[c][0])) + 50'(floor_q16(np_q[c][1]))
              + 50'(floor_q16(np_q[c][2]));
    end
  end

  // saturation to 32 bits
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (ps_q[c] > SatMax)      po[c] = SatMax[31:0];
      else if (ps_q[c] < SatMin) po[c] = SatMin[31:0];
      else                       po[c] = ps_q[c][31:0];
      if (ns_q[c] > SatMax)      no[c] = SatMax[31:0];
      else if (ns_q[c] < SatMin) no[c] = SatMin[31:0];
      else                       no[c] = ns_q[c][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) v4_q <= valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      pp_q     <= pp_d;
      np_q     <= np_d;
      tr_q     <= {blend_i.mat[TransRow+2], blend_i.mat[TransRow+1], blend_i.mat[TransRow]};
      clamp4_q <= blend_i.clamped;
    end
    if (en5) begin
      ps_q     <= ps_d;
      ns_q     <= ns_d;
      clamp5_q <= clamp4_q;
    end
    if (en6) begin
      out_q.out_pos_x     <= po[0];
      out_q.out_pos_y     <= po[1];
      out_q.out_pos_z     <= po[2];
      out_q.out_nrm_x     <= no[0];
      out_q.out_nrm_y     <= no[1];
      out_q.out_nrm_z     <= no[2];
      out_q.joint_clamped <= clamp5_q;
    end
  end

  assign res_o.valid = v6_q;
  assign res_o.data  = out_q;

endmodule

>>> rtl/core/two_joint_vertex_skinning.sv
// two-joint linear blend skinning, top level
// throughput: one item per cycle; the stages only hold on output backpressure
// stages: table read, blend multiply, blend add, transform multiply, sum, saturate
// reset clears the stage valid bits only; matrix words stay undefined until loaded
module two_joint_vertex_skinning #(
  parameter int JOINTS = tjs_pkg::JointsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tjs_in_if.sink    vtx_i,
  tjs_out_if.source res_o
);
  import tjs_pkg::*;

  localparam int AW = $clog2(JOINTS);
  localparam logic [JIdxW-1:0] JointsW = JIdxW'(JOINTS);
  localparam logic [AW-1:0]    LastJ   = AW'(JOINTS - 1);

  logic             v1_q, en1, blend_ready;
  logic             xfer, load_ok;
  logic [JIdxW-1:0] j0w, j1w;
  logic             clamp_d;
  logic [AW-1:0]    ra, rb, wa;
  tjs_fetch_t       fetch;
  logic [15:0]      frac_q;
  vec3_t            pos_q, nrm_q;
  logic             clamp_q;
  logic             bl_valid, xf_ready;
  tjs_blend_t       bl;

  assign en1         = !v1_q || blend_ready;
  assign vtx_i.ready = en1;
  assign xfer        = vtx_i.valid && en1;

  // joint pair with clamping at the end of the table
  assign j0w     = JIdxW'(vtx_i.data.blend_weight[20:16]);
  assign j1w     = j0w + JIdxW'(1);
  assign clamp_d = (j1w >= JointsW);
  assign ra      = clamp_d ? LastJ : AW'(j0w);
  assign rb      = clamp_d ? LastJ : AW'(j1w);

  // load write, ignored outside the table
  assign load_ok = xfer && (vtx_i.data.kind == KIND_LOAD)
                   && (JIdxW'(vtx_i.data.load_joint) < JointsW);
  assign wa      = AW'(vtx_i.data.load_joint);

  // one table per matrix word, read for both joints at once
  for (genvar e = 0; e < Words; e++) begin : g_word
    logic [31:0] rd_a, rd_b;
    tjs_ram #(
      .Width (32),
      .Depth (JOINTS)
    ) u_ram (
      .clk_i     (clk_i),
      .we_i      (load_ok && (vtx_i.data.load_element == 4'(e))),
      .waddr_i   (wa),
      .wdata_i   (vtx_i.data.load_value),
      .re_i      (en1),
      .raddr_a_i (ra),
      .raddr_b_i (rb),
      .rdata_a_o (rd_a),
      .rdata_b_o (rd_b)
    );
    assign fetch.mat_a[e] = rd_a;
    assign fetch.mat_b[e] = rd_b;
  end

  // vertex side data alongside the table read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= vtx_i.valid && (vtx_i.data.kind == KIND_VERTEX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      frac_q  <= vtx_i.data.blend_weight[15:0];
      pos_q   <= {vtx_i.data.pos_z, vtx_i.data.pos_y, vtx_i.data.pos_x};
      nrm_q   <= {vtx_i.data.nrm_z, vtx_i.data.nrm_y, vtx_i.data.nrm_x};
      clamp_q <= clamp_d;
    end
  end

  assign fetch.frac    = frac_q;
  assign fetch.pos     = pos_q;
  assign fetch.nrm     = nrm_q;
  assign fetch.clamped = clamp_q;

  tjs_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .ready_o (blend_ready),
    .fetch_i (fetch),
    .valid_o (bl_valid),
    .ready_i (xf_ready),
    .blend_o (bl)
  );

  tjs_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bl_valid),
    .ready_o (xf_ready),
    .blend_i (bl),
    .res_o   (res_o)
  );

endmodule
